/* rtl/yeoh_hyperelastic_stress_macros.svh */
// assertion macros for the yeoh stress block
// used by the top level; needs clk and arst_n in the including scope
`ifndef YEOH_HYPERELASTIC_STRESS_MACROS_SVH
`define YEOH_HYPERELASTIC_STRESS_MACROS_SVH
`ifndef SYNTH
`define YHS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define YHS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define YHS_ASSERT_IMP(label, ante, cons, msg)
`define YHS_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

/* rtl/yhs_pkg.sv */
// shared types, constants and saturating helpers for the yeoh stress block
// no dependencies
package yhs_pkg;
	localparam int FRAC_BITS  = 24;
	localparam int COEF_FRAC  = 16;
	localparam int STRAIN_W   = 32;
	localparam int COEF_W     = 32;
	localparam int OUT_W      = 48;
	localparam int VAL_W      = 63;
	localparam int MAG_W      = VAL_W - 1;
	localparam int MUL_LAT    = 3;
	localparam int DIV_STEP   = 4;
	localparam int QUOT_W     = 2 * FRAC_BITS + 1;
	localparam int DIV_STAGES = (QUOT_W + DIV_STEP - 1) / DIV_STEP;
	localparam int DIV_BITS   = DIV_STAGES * DIV_STEP;
	localparam int REG_IDX_W  = 4;

	typedef logic signed [VAL_W-1:0] val_t;
	typedef logic signed [OUT_W-1:0] out_t;
	typedef struct packed {
		logic sat;
		val_t v;
	} sum_t;
	typedef struct packed {
		logic sat;
		out_t v;
	} osum_t;

	localparam val_t LIMIT     = {1'b0, {MAG_W{1'b1}}};
	localparam val_t NEG_LIMIT = -LIMIT;
	localparam val_t ONE       = val_t'(1) <<< FRAC_BITS;
	localparam val_t THREE_ONE = val_t'(3) <<< FRAC_BITS;
	localparam out_t OUT_MAX   = {1'b0, {(OUT_W-1){1'b1}}};
	localparam out_t OUT_MIN   = {1'b1, {(OUT_W-1){1'b0}}};

	localparam logic [1:0] MODE_UNI    = 2'd0;
	localparam logic [1:0] MODE_EQUI   = 2'd1;
	localparam logic [1:0] MODE_PLANAR = 2'd2;
	localparam logic [1:0] MODE_BAD    = 2'd3;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_BAD_MODE = 2'd1;
	localparam logic [1:0] STAT_NONPOS   = 2'd2;
	localparam logic [1:0] STAT_SAT      = 2'd3;

	localparam logic [REG_IDX_W-1:0] REG_TEST_MODE = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_COEF_C10  = REG_IDX_W'(1);
	localparam logic [REG_IDX_W-1:0] REG_COEF_C20  = REG_IDX_W'(2);
	localparam logic [REG_IDX_W-1:0] REG_COEF_C30  = REG_IDX_W'(3);

	// clamped add or subtract
	function automatic sum_t csum(val_t a, val_t b, logic sub);
		logic signed [VAL_W:0] x;
		sum_t r;
		x = sub ? ((VAL_W+1)'(a) - (VAL_W+1)'(b)) : ((VAL_W+1)'(a) + (VAL_W+1)'(b));
		if (x > (VAL_W+1)'(LIMIT)) begin
			r.sat = 1'b1;
			r.v = LIMIT;
		end else if (x < (VAL_W+1)'(NEG_LIMIT)) begin
			r.sat = 1'b1;
			r.v = NEG_LIMIT;
		end else begin
			r.sat = 1'b0;
			r.v = VAL_W'(x);
		end
		return r;
	endfunction

	// clamp to the output range
	function automatic osum_t oclamp(val_t a);
		osum_t r;
		if (a > val_t'(OUT_MAX)) begin
			r.sat = 1'b1;
			r.v = OUT_MAX;
		end else if (a < val_t'(OUT_MIN)) begin
			r.sat = 1'b1;
			r.v = OUT_MIN;
		end else begin
			r.sat = 1'b0;
			r.v = OUT_W'(a);
		end
		return r;
	endfunction
endpackage

/* rtl/yhs_in_if.sv */
// strain sample channel
// depends on yhs_pkg
interface yhs_in_if;
	logic valid;
	logic ready;
	logic signed [yhs_pkg::STRAIN_W-1:0] strain_sample;
	modport source(output valid, output strain_sample, input ready);
	modport sink(input valid, input strain_sample, output ready);
endinterface

/* rtl/yhs_out_if.sv */
// stress result channel
// depends on yhs_pkg
interface yhs_out_if;
	logic valid;
	logic ready;
	logic signed [yhs_pkg::OUT_W-1:0] stress_value;
	logic [yhs_pkg::STRAIN_W-1:0] stretch_value;
	logic signed [yhs_pkg::OUT_W-1:0] transverse_value;
	logic transverse_valid;
	logic [1:0] status_code;
	modport source(output valid, output stress_value, output stretch_value,
		output transverse_value, output transverse_valid, output status_code, input ready);
	modport sink(input valid, input stress_value, input stretch_value,
		input transverse_value, input transverse_valid, input status_code, output ready);
endinterface

/* rtl/yhs_cfg_if.sv */
// register write channel
// depends on yhs_pkg
interface yhs_cfg_if;
	logic valid;
	logic ready;
	logic [yhs_pkg::REG_IDX_W-1:0] index;
	logic [yhs_pkg::COEF_W-1:0] data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

/* rtl/yhs_div.sv */
// pipelined restoring divider, DIV_STEP quotient bits per stage
// depends on yhs_pkg
module yhs_div (
	input  logic clk,
	input  logic en,
	input  logic [yhs_pkg::DIV_BITS-1:0] dividend,
	input  logic [yhs_pkg::STRAIN_W-1:0] divisor,
	output logic [yhs_pkg::QUOT_W-1:0] quot
);
	localparam int NB = yhs_pkg::DIV_BITS;
	localparam int DW = yhs_pkg::STRAIN_W;
	localparam int NS = yhs_pkg::DIV_STAGES;

	logic [DW-1:0] rem_s [1:NS];
	logic [NB-1:0] nq_s  [1:NS];
	logic [DW-1:0] dvs_s [1:NS];

	for (genvar g = 0; g < NS; g++) begin : g_stage
		logic [DW-1:0] rem_i;
		logic [NB-1:0] nq_i;
		logic [DW-1:0] dvs_i;
		logic [DW-1:0] rem_n;
		logic [NB-1:0] nq_n;
		if (g == 0) begin : g_first
			assign rem_i = '0;
			assign nq_i = dividend;
			assign dvs_i = divisor;
		end else begin : g_next
			assign rem_i = rem_s[g];
			assign nq_i = nq_s[g];
			assign dvs_i = dvs_s[g];
		end
		always_comb begin : b_step
			logic [DW:0] trial;
			logic [DW-1:0] rem_v;
			logic [NB-1:0] nq_v;
			rem_v = rem_i;
			nq_v = nq_i;
			for (int k = 0; k < yhs_pkg::DIV_STEP; k++) begin
				trial = {rem_v, nq_v[NB-1]};
				if (trial >= {1'b0, dvs_i}) begin
					rem_v = DW'(trial - {1'b0, dvs_i});
					nq_v = {nq_v[NB-2:0], 1'b1};
				end else begin
					rem_v = trial[DW-1:0];
					nq_v = {nq_v[NB-2:0], 1'b0};
				end
			end
			rem_n = rem_v;
			nq_n = nq_v;
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g+1] <= rem_n;
				nq_s[g+1] <= nq_n;
				dvs_s[g+1] <= dvs_i;
			end
		end
	end

	assign quot = nq_s[NS][yhs_pkg::QUOT_W-1:0];
endmodule

/* rtl/yhs_mul.sv */
// signed fixed point multiplier, rounded half away from zero, clamped
// three register stages; depends on yhs_pkg
module yhs_mul (
	input  logic clk,
	input  logic en,
	input  yhs_pkg::val_t a,
	input  yhs_pkg::val_t b,
	output yhs_pkg::val_t p,
	output logic sat
);
	localparam int MW = yhs_pkg::MAG_W;
	localparam int LW = 32;
	localparam int HW = MW - LW;
	localparam int PW = 2 * MW + 1;

	logic [MW-1:0] mag_a_s1, mag_b_s1;
	logic neg_s1, neg_s2;
	logic [2*LW-1:0] ll_s2;
	logic [LW+HW-1:0] lh_s2, hl_s2;
	logic [2*HW-1:0] hh_s2;
	logic [PW-1:0] prod, quo;
	logic over;
	yhs_pkg::val_t mag_v;

	always_ff @(posedge clk) begin
		if (en) begin
			mag_a_s1 <= a[yhs_pkg::VAL_W-1] ? MW'(-a) : a[MW-1:0];
			mag_b_s1 <= b[yhs_pkg::VAL_W-1] ? MW'(-b) : b[MW-1:0];
			neg_s1 <= a[yhs_pkg::VAL_W-1] ^ b[yhs_pkg::VAL_W-1];
			ll_s2 <= mag_a_s1[LW-1:0] * mag_b_s1[LW-1:0];
			lh_s2 <= mag_a_s1[LW-1:0] * mag_b_s1[MW-1:LW];
			hl_s2 <= mag_a_s1[MW-1:LW] * mag_b_s1[LW-1:0];
			hh_s2 <= mag_a_s1[MW-1:LW] * mag_b_s1[MW-1:LW];
			neg_s2 <= neg_s1;
			p <= neg_s2 ? -mag_v : mag_v;
			sat <= over;
		end
	end

	always_comb begin
		prod = PW'(ll_s2) + (PW'(lh_s2) << LW) + (PW'(hl_s2) << LW) + (PW'(hh_s2) << (2 * LW))
			+ (PW'(1) << (yhs_pkg::FRAC_BITS - 1));
		quo = prod >> yhs_pkg::FRAC_BITS;
		over = quo > PW'(yhs_pkg::LIMIT);
		mag_v = over ? yhs_pkg::LIMIT : yhs_pkg::val_t'({1'b0, quo[MW-1:0]});
	end
endmodule

/* rtl/yeoh_hyperelastic_stress.sv */
// Yeoh hyperelastic nominal stress, one strain sample per beat. Stretch
// s = strain + 1 (Q8.24) feeds a 13-stage restoring divider for 1/s, then six
// levels of pipelined multipliers form the powers of s, the invariant, the Yeoh
// polynomial and the stress and planar transverse term. Every stage is a
// register with a valid bit; the whole pipe advances when the output register
// is empty or taken, so a new sample is accepted every cycle unless a held
// output stalls the pipe. Latency is set by the divider depth plus the
// multiplier chain. Registers: test_mode, coef_c10, coef_c20, coef_c30,
// written through cfg (always ready); write only while the pipe is empty.
// Status: invalid mode, stretch not positive, saturated.
// depends on yhs_pkg, yhs_in_if, yhs_out_if, yhs_cfg_if, yhs_div, yhs_mul
`include "yeoh_hyperelastic_stress_macros.svh"
module yeoh_hyperelastic_stress (
	input logic clk,
	input logic arst_n,
	yhs_cfg_if.sink cfg,
	yhs_in_if.sink samples,
	yhs_out_if.source results
);
	localparam int L  = yhs_pkg::MUL_LAT;
	localparam int KR = 1 + yhs_pkg::DIV_STAGES;  // reciprocal ready
	localparam int K1 = KR + L;                   // s^2, s^-2 ready
	localparam int K2 = K1 + L;                   // s^-3 or s^-4
	localparam int K3 = K2 + L;                   // s^-5 or transverse factor
	localparam int KB = K3 + 1;                   // invariant stage
	localparam int KD = K3 + 2;                   // d = I - 3
	localparam int K4I = K3 + 3;                  // d registered
	localparam int K4 = K4I + L;                  // c20*d, d*d
	localparam int K5 = K4 + L;                   // c30*d^2
	localparam int KP = K5 + 3;                   // polynomial ready
	localparam int K6 = KP + L;                   // final products

	// config registers
	logic [1:0] mode_q;
	logic signed [yhs_pkg::COEF_W-1:0] c10_q, c20_q, c30_q;
	yhs_pkg::val_t c10s, c20s, c30s;

	// pipeline control
	logic adv;
	logic vld_s [1:K6];
	logic vld_s39;

	// payload pipes
	logic signed [yhs_pkg::STRAIN_W:0] str_s [1:K6];
	yhs_pkg::val_t r_s    [KR+1:K3];
	yhs_pkg::val_t s2_s   [K1+1:KB];
	yhs_pkg::val_t r2_s   [K1+1:K3];
	yhs_pkg::val_t s2m1_s [K1+1:K2];
	yhs_pkg::val_t m2_s   [K2+1:KB];
	yhs_pkg::val_t m3_s   [K3+1:KP];
	yhs_pkg::val_t lam_s  [KB:KP];
	yhs_pkg::val_t b_s    [K4+2:K5+2];
	logic sat_s [K1+1:K6];
	yhs_pkg::val_t usum_s24, inv_s25, d_s26, a2_s30, e_s33, t2_s33, f_s34, poly_s35;

	// output register
	yhs_pkg::out_t stress_s39, trans_s39;
	logic [yhs_pkg::STRAIN_W-1:0] stretch_s39;
	logic tv_s39;
	logic [1:0] stat_s39;

	// unit ports
	logic [yhs_pkg::QUOT_W-1:0] recip;
	yhs_pkg::val_t recip_v, str_k1, str_k3;
	yhs_pkg::val_t m1a_p, m1b_p, m2_p, m3_p, m4a_p, m4b_p, m5_p, m6a_p, m6b_p;
	logic m1a_sat, m1b_sat, m2_sat, m3_sat, m4a_sat, m4b_sat, m5_sat, m6a_sat, m6b_sat;
	yhs_pkg::val_t m2_b, m3_a, m3_b;
	logic is_equi, is_planar, is_uni;

	// stage sums
	yhs_pkg::sum_t s2m1_c, usum_c, lam_c, inv_c, d_c, a2_c, b_c, e_c, f_c, poly_c;
	yhs_pkg::sum_t st_c, tr_c;
	yhs_pkg::osum_t st_o, tr_o;
	logic fin_sat;

	assign is_uni = mode_q == yhs_pkg::MODE_UNI;
	assign is_equi = mode_q == yhs_pkg::MODE_EQUI;
	assign is_planar = mode_q == yhs_pkg::MODE_PLANAR;

	// coefficients to FRAC_BITS fractional bits
	assign c10s = yhs_pkg::val_t'(c10_q) <<< (yhs_pkg::FRAC_BITS - yhs_pkg::COEF_FRAC);
	assign c20s = yhs_pkg::val_t'(c20_q) <<< (yhs_pkg::FRAC_BITS - yhs_pkg::COEF_FRAC);
	assign c30s = yhs_pkg::val_t'(c30_q) <<< (yhs_pkg::FRAC_BITS - yhs_pkg::COEF_FRAC);

	// the pipe moves as one; a held output stalls everything behind it
	assign adv = !vld_s39 || results.ready;
	assign samples.ready = adv;
	assign cfg.ready = 1'b1;

	// config port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= yhs_pkg::MODE_UNI;
			c10_q <= '0;
			c20_q <= '0;
			c30_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				yhs_pkg::REG_TEST_MODE: mode_q <= cfg.data[1:0];
				yhs_pkg::REG_COEF_C10: c10_q <= cfg.data;
				yhs_pkg::REG_COEF_C20: c20_q <= cfg.data;
				yhs_pkg::REG_COEF_C30: c30_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= K6; k++) vld_s[k] <= 1'b0;
			vld_s39 <= 1'b0;
		end else if (adv) begin
			vld_s[1] <= samples.valid;
			for (int k = 2; k <= K6; k++) vld_s[k] <= vld_s[k-1];
			vld_s39 <= vld_s[K6];
		end
	end

	// reciprocal: floor((2^2F + floor(S/2)) / S)
	yhs_div u_div (
		.clk(clk),
		.en(adv),
		.dividend(yhs_pkg::DIV_BITS'((yhs_pkg::DIV_BITS'(1) << (2 * yhs_pkg::FRAC_BITS))
			+ yhs_pkg::DIV_BITS'(str_s[1][yhs_pkg::STRAIN_W-1:1]))),
		.divisor(str_s[1][yhs_pkg::STRAIN_W-1:0]),
		.quot(recip)
	);

	assign recip_v = yhs_pkg::val_t'(recip);
	assign str_k1 = yhs_pkg::val_t'(str_s[KR]);
	assign str_k3 = yhs_pkg::val_t'(str_s[K3]);

	// level 1: s^2 and s^-2
	yhs_mul u_mul_s2 (.clk(clk), .en(adv), .a(str_k1), .b(str_k1), .p(m1a_p), .sat(m1a_sat));
	yhs_mul u_mul_r2 (.clk(clk), .en(adv), .a(recip_v), .b(recip_v), .p(m1b_p), .sat(m1b_sat));

	// level 2: s^-4 for equibiaxial, s^-3 otherwise
	assign m2_b = is_equi ? m1b_p : r_s[K1];
	yhs_mul u_mul_l2 (.clk(clk), .en(adv), .a(m1b_p), .b(m2_b), .p(m2_p), .sat(m2_sat));

	// level 3: s^-5 for equibiaxial, transverse factor otherwise
	assign m3_a = is_equi ? m2_p : s2m1_s[K2];
	assign m3_b = is_equi ? r_s[K2] : m2_p;
	yhs_mul u_mul_l3 (.clk(clk), .en(adv), .a(m3_a), .b(m3_b), .p(m3_p), .sat(m3_sat));

	// level 4: c20*d and d*d
	yhs_mul u_mul_t1 (.clk(clk), .en(adv), .a(c20s), .b(d_s26), .p(m4a_p), .sat(m4a_sat));
	yhs_mul u_mul_dd (.clk(clk), .en(adv), .a(d_s26), .b(d_s26), .p(m4b_p), .sat(m4b_sat));

	// level 5: c30*d^2
	yhs_mul u_mul_t2 (.clk(clk), .en(adv), .a(c30s), .b(m4b_p), .p(m5_p), .sat(m5_sat));

	// level 6: stress and transverse products
	yhs_mul u_mul_st (.clk(clk), .en(adv), .a(lam_s[KP]), .b(poly_s35), .p(m6a_p),
		.sat(m6a_sat));
	yhs_mul u_mul_tr (.clk(clk), .en(adv), .a(m3_s[KP]), .b(poly_s35), .p(m6b_p),
		.sat(m6b_sat));

	// clamped sums between the multiplier levels
	always_comb begin
		s2m1_c = yhs_pkg::csum(m1a_p, yhs_pkg::ONE, 1'b1);
		case (mode_q)
			yhs_pkg::MODE_UNI: begin
				usum_c = yhs_pkg::csum(r_s[K3], r_s[K3], 1'b0);
				lam_c = yhs_pkg::csum(str_k3, r2_s[K3], 1'b1);
				inv_c = yhs_pkg::csum(s2_s[KB], usum_s24, 1'b0);
			end
			yhs_pkg::MODE_EQUI: begin
				usum_c = yhs_pkg::csum(s2_s[K3], s2_s[K3], 1'b0);
				lam_c = yhs_pkg::csum(str_k3, m3_p, 1'b1);
				inv_c = yhs_pkg::csum(usum_s24, m2_s[KB], 1'b0);
			end
			default: begin
				usum_c = yhs_pkg::csum(s2_s[K3], r2_s[K3], 1'b0);
				lam_c = yhs_pkg::csum(str_k3, m2_s[K3], 1'b1);
				inv_c = yhs_pkg::csum(usum_s24, yhs_pkg::ONE, 1'b0);
			end
		endcase
		d_c = yhs_pkg::csum(inv_s25, yhs_pkg::THREE_ONE, 1'b1);
		a2_c = yhs_pkg::csum(m4a_p, m4a_p, 1'b0);
		b_c = yhs_pkg::csum(c10s, a2_s30, 1'b0);
		e_c = yhs_pkg::csum(m5_p, m5_p, 1'b0);
		f_c = yhs_pkg::csum(e_s33, t2_s33, 1'b0);
		poly_c = yhs_pkg::csum(b_s[K5+2], f_s34, 1'b0);
		// doubling and output clamp
		st_c = yhs_pkg::csum(m6a_p, m6a_p, 1'b0);
		tr_c = yhs_pkg::csum(m6b_p, m6b_p, 1'b0);
		st_o = yhs_pkg::oclamp(st_c.v);
		tr_o = yhs_pkg::oclamp(tr_c.v);
		fin_sat = sat_s[K6] | m6a_sat | st_c.sat | st_o.sat
			| (is_planar & (m6b_sat | tr_c.sat | tr_o.sat));
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (adv) begin
			str_s[1] <= (yhs_pkg::STRAIN_W+1)'(samples.strain_sample)
				+ ((yhs_pkg::STRAIN_W+1)'(1) <<< yhs_pkg::FRAC_BITS);
			for (int k = 2; k <= K6; k++) str_s[k] <= str_s[k-1];

			r_s[KR+1] <= recip_v;
			for (int k = KR + 2; k <= K3; k++) r_s[k] <= r_s[k-1];

			s2_s[K1+1] <= m1a_p;
			for (int k = K1 + 2; k <= KB; k++) s2_s[k] <= s2_s[k-1];
			r2_s[K1+1] <= m1b_p;
			for (int k = K1 + 2; k <= K3; k++) r2_s[k] <= r2_s[k-1];
			s2m1_s[K1+1] <= s2m1_c.v;
			for (int k = K1 + 2; k <= K2; k++) s2m1_s[k] <= s2m1_s[k-1];

			m2_s[K2+1] <= m2_p;
			for (int k = K2 + 2; k <= KB; k++) m2_s[k] <= m2_s[k-1];
			m3_s[K3+1] <= m3_p;
			for (int k = K3 + 2; k <= KP; k++) m3_s[k] <= m3_s[k-1];

			usum_s24 <= usum_c.v;
			lam_s[KB] <= lam_c.v;
			for (int k = KB + 1; k <= KP; k++) lam_s[k] <= lam_s[k-1];
			inv_s25 <= inv_c.v;
			d_s26 <= d_c.v;

			a2_s30 <= a2_c.v;
			b_s[K4+2] <= b_c.v;
			for (int k = K4 + 3; k <= K5 + 2; k++) b_s[k] <= b_s[k-1];
			e_s33 <= e_c.v;
			t2_s33 <= m5_p;
			f_s34 <= f_c.v;
			poly_s35 <= poly_c.v;

			// saturation seen so far, only from steps the mode really uses
			for (int k = K1 + 2; k <= K2; k++) sat_s[k] <= sat_s[k-1];
			for (int k = K2 + 2; k <= K3; k++) sat_s[k] <= sat_s[k-1];
			for (int k = K4I + 1; k <= K4; k++) sat_s[k] <= sat_s[k-1];
			for (int k = K4 + 3; k <= K5; k++) sat_s[k] <= sat_s[k-1];
			for (int k = KP + 1; k <= K6; k++) sat_s[k] <= sat_s[k-1];
			sat_s[K1+1] <= m1a_sat | m1b_sat | (is_planar & s2m1_c.sat);
			sat_s[K2+1] <= sat_s[K2] | (!is_uni & m2_sat);
			sat_s[KB] <= sat_s[K3] | (mode_q inside {yhs_pkg::MODE_EQUI, yhs_pkg::MODE_PLANAR}
				? m3_sat : 1'b0) | usum_c.sat | lam_c.sat;
			sat_s[KD] <= sat_s[KB] | inv_c.sat;
			sat_s[K4I] <= sat_s[KD] | d_c.sat;
			sat_s[K4+1] <= sat_s[K4] | m4a_sat | m4b_sat | a2_c.sat;
			sat_s[K4+2] <= sat_s[K4+1] | b_c.sat;
			sat_s[K5+1] <= sat_s[K5] | m5_sat | e_c.sat;
			sat_s[K5+2] <= sat_s[K5+1] | f_c.sat;
			sat_s[KP] <= sat_s[K5+2] | poly_c.sat;

			// output register with the special cases in priority order
			if (mode_q == yhs_pkg::MODE_BAD) begin
				stress_s39 <= '0;
				stretch_s39 <= '0;
				trans_s39 <= '0;
				tv_s39 <= 1'b0;
				stat_s39 <= yhs_pkg::STAT_BAD_MODE;
			end else if (str_s[K6] <= 0) begin
				stress_s39 <= '0;
				stretch_s39 <= '0;
				trans_s39 <= '0;
				tv_s39 <= 1'b0;
				stat_s39 <= yhs_pkg::STAT_NONPOS;
			end else begin
				stress_s39 <= st_o.v;
				stretch_s39 <= str_s[K6][yhs_pkg::STRAIN_W-1:0];
				trans_s39 <= is_planar ? tr_o.v : '0;
				tv_s39 <= is_planar;
				stat_s39 <= fin_sat ? yhs_pkg::STAT_SAT : yhs_pkg::STAT_OK;
			end
		end
	end

	assign results.valid = vld_s39;
	assign results.stress_value = stress_s39;
	assign results.stretch_value = stretch_s39;
	assign results.transverse_value = trans_s39;
	assign results.transverse_valid = tv_s39;
	assign results.status_code = stat_s39;

	// checks
	`YHS_ASSERT_NEXT(a_last_stage_drains, vld_s[K6] && adv, results.valid,
		"last stage beat lost")
	`YHS_ASSERT_IMP(a_bad_mode_zero,
		results.valid && results.status_code == yhs_pkg::STAT_BAD_MODE,
		results.stress_value == '0 && results.stretch_value == '0 && !results.transverse_valid,
		"invalid mode result not cleared")
	`YHS_ASSERT_IMP(a_nonpos_zero,
		results.valid && results.status_code == yhs_pkg::STAT_NONPOS,
		results.stress_value == '0 && results.transverse_value == '0
			&& !results.transverse_valid,
		"nonpositive stretch result not cleared")
	`YHS_ASSERT_IMP(a_trans_gated, results.valid && !results.transverse_valid,
		results.transverse_value == '0, "transverse term outside planar")
endmodule
